// ----- hw/rtl/fmcd_pkg.sv -----
// Shared types, constants and helper functions of the coherence directory.
package fmcd_pkg;

	localparam int ENTRIES   = 256;
	localparam int NUM_PROCS = 8;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int PROC_W    = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int ADDR_W    = 32;
	localparam int TAG_W     = 32;
	localparam int REQ_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0]  REG_OFFSET_BITS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0]  REG_ACTIVE_PROCS = 2'd1;
	localparam logic [CFG_DATA_W-1:0] OFFSET_RESET     = 4'd6;
	localparam logic [CFG_DATA_W-1:0] ACTIVE_RESET     = 4'd8;

	typedef enum logic [1:0] {
		CMD_READ,
		CMD_READ_EXCL,
		CMD_UPGRADE,
		CMD_UNCACHE
	} cmd_t;

	typedef enum logic [1:0] {
		MSG_INTERVENE,
		MSG_INVALIDATE,
		MSG_TRANSFER,
		MSG_COMPLETE
	} msg_t;

	typedef enum logic [1:0] {
		DS_UNCACHED,
		DS_EXCL,
		DS_SHARED
	} dstate_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_FULL,
		ST_MISSING
	} status_t;

	// One directory entry as stored in the RAM
	typedef struct packed {
		logic [TAG_W-1:0]     tag;
		logic [1:0]           st;
		logic [NUM_PROCS-1:0] sharers;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Message sequence handed from the directory control to the emitter
	typedef struct packed {
		logic                 pre_xfer;
		logic                 post_xfer;
		logic [1:0]           scan_kind;
		logic [NUM_PROCS-1:0] mask;
		logic [REQ_W-1:0]     req;
		logic [ADDR_W-1:0]    addr;
		logic [1:0]           grant;
		logic [1:0]           status;
	} emit_job_t;

	typedef struct packed {
		logic busy;
		logic done;
	} emit_stat_t;

	// Presence bit of one processor; none for a processor beyond the map
	function automatic logic [NUM_PROCS-1:0] proc_bit(input logic [REQ_W-1:0] p);
		logic [NUM_PROCS-1:0] b;
		for (int i = 0; i < NUM_PROCS; i++) begin
			b[i] = (32'(p) == i);
		end
		return b;
	endfunction

	// Sharer bits covered by the scan, lower of active count and map size
	function automatic logic [NUM_PROCS-1:0] scan_mask(input logic [CFG_DATA_W-1:0] act);
		logic [NUM_PROCS-1:0] m;
		for (int i = 0; i < NUM_PROCS; i++) begin
			m[i] = (32'(act) > i);
		end
		return m;
	endfunction

endpackage

// ----- hw/rtl/fmcd_if.sv -----
// Handshake channel interfaces: request, response and configuration write.
interface fmcd_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    cmd;
	logic [fmcd_pkg::ADDR_W-1:0]   req_addr;
	logic [fmcd_pkg::REQ_W-1:0]    requester;

	modport source (output valid, output cmd, output req_addr, output requester, input ready);
	modport sink   (input valid, input cmd, input req_addr, input requester, output ready);
endinterface

interface fmcd_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    msg_kind;
	logic [fmcd_pkg::REQ_W-1:0]    target_proc;
	logic [fmcd_pkg::ADDR_W-1:0]   msg_addr;
	logic [1:0]                    granted_state;
	logic [1:0]                    status;
	logic                          last;

	modport source (output valid, output msg_kind, output target_proc, output msg_addr,
		output granted_state, output status, output last, input ready);
	modport sink   (input valid, input msg_kind, input target_proc, input msg_addr,
		input granted_state, input status, input last, output ready);
endinterface

interface fmcd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [fmcd_pkg::CFG_IDX_W-1:0]  index;
	logic [fmcd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/fmcd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module fmcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/fmcd_emit.sv -----
// Message sequencer: walks the sharer mask and drives the response register.
module fmcd_emit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  fmcd_pkg::emit_job_t   job,
	output fmcd_pkg::emit_stat_t  stat,
	fmcd_rsp_if.source            rsp
);

	typedef enum logic [2:0] {
		E_IDLE,
		E_PRE,
		E_SCAN,
		E_POST,
		E_DONE
	} estate_t;

	estate_t                       st_q, st_d;
	fmcd_pkg::emit_job_t           job_q;
	logic [fmcd_pkg::PROC_W-1:0]   p_q;
	logic                          vld_q, done_q;
	logic [1:0]                    kind_q, grant_q, status_q;
	logic [fmcd_pkg::REQ_W-1:0]    proc_q;
	logic [fmcd_pkg::ADDR_W-1:0]   addr_q;
	logic                          last_q;

	logic                          slot_free, cur_bit, last_p, step_p;
	logic                          ld, ld_last;
	logic [1:0]                    ld_kind, ld_grant, ld_status;
	logic [fmcd_pkg::REQ_W-1:0]    ld_proc;

	assign slot_free = !vld_q || rsp.ready;
	assign cur_bit   = job_q.mask[p_q];
	assign last_p    = (p_q == fmcd_pkg::PROC_W'(fmcd_pkg::NUM_PROCS - 1));

	// Pick the next item and the next phase
	always_comb begin
		st_d      = st_q;
		ld        = 1'b0;
		step_p    = 1'b0;
		ld_kind   = fmcd_pkg::MSG_COMPLETE;
		ld_proc   = job_q.req;
		ld_grant  = fmcd_pkg::DS_UNCACHED;
		ld_status = fmcd_pkg::ST_OK;
		ld_last   = 1'b0;
		case (st_q)
			E_IDLE: begin
				if (start) begin
					st_d = job.pre_xfer ? E_PRE : E_SCAN;
				end
			end
			E_PRE: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_kind = fmcd_pkg::MSG_TRANSFER;
					st_d    = E_SCAN;
				end
			end
			E_SCAN: begin
				if (!cur_bit || slot_free) begin
					ld      = cur_bit;
					ld_kind = job_q.scan_kind;
					ld_proc = fmcd_pkg::REQ_W'(p_q);
					step_p  = 1'b1;
					if (last_p) begin
						st_d = job_q.post_xfer ? E_POST : E_DONE;
					end
				end
			end
			E_POST: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_kind = fmcd_pkg::MSG_TRANSFER;
					st_d    = E_DONE;
				end
			end
			E_DONE: begin
				if (slot_free) begin
					ld        = 1'b1;
					ld_grant  = job_q.grant;
					ld_status = job_q.status;
					ld_last   = 1'b1;
					st_d      = E_IDLE;
				end
			end
			default: st_d = E_IDLE;
		endcase
	end

	// Hold state, the processor walk and the response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= E_IDLE;
			p_q    <= '0;
			vld_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == E_DONE) && slot_free;
			if (st_q == E_IDLE && start) begin
				job_q <= job;
				p_q   <= '0;
			end else if (step_p) begin
				p_q <= fmcd_pkg::PROC_W'(p_q + 1'b1);
			end
			if (ld) begin
				vld_q    <= 1'b1;
				kind_q   <= ld_kind;
				proc_q   <= ld_proc;
				addr_q   <= job_q.addr;
				grant_q  <= ld_grant;
				status_q <= ld_status;
				last_q   <= ld_last;
			end else if (rsp.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = vld_q;
	assign rsp.msg_kind      = kind_q;
	assign rsp.target_proc   = proc_q;
	assign rsp.msg_addr      = addr_q;
	assign rsp.granted_state = grant_q;
	assign rsp.status        = status_q;
	assign rsp.last          = last_q;

	assign stat.busy = (st_q != E_IDLE);
	assign stat.done = done_q;

endmodule

// ----- hw/rtl/full_map_coherence_directory_core.sv -----
// Full-map MSI coherence directory: entry RAM scan, update and message control.
// The completion follows the tag search over every entry and the sharer walk, after a transfer if due.
// Requests are taken one at a time, only once the emitter has loaded the previous completion;
// the tag search and the walk over every sharer bit set the pace, and response stalls slow it.
// Reset: valid bits clear at once, so every entry reads free; no clearing pass.
// Reset loads offset_bits = 6 and active_procs = 8.
module full_map_coherence_directory_core (
	input  logic         clk,
	input  logic         arst_n,
	fmcd_req_if.sink     req,
	fmcd_rsp_if.source   rsp,
	fmcd_cfg_if.sink     cfg
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_RESOLVE,
		S_EMIT
	} state_t;

	state_t                              state_q;
	logic [fmcd_pkg::CFG_DATA_W-1:0]     offset_q, active_q;
	fmcd_pkg::cmd_t                      cmd_q;
	logic [fmcd_pkg::ADDR_W-1:0]         addr_q;
	logic [fmcd_pkg::REQ_W-1:0]          reqr_q;
	logic [fmcd_pkg::TAG_W-1:0]          tag_q;
	logic [fmcd_pkg::IDX_W-1:0]          cnt_q;
	logic                                rd_vld_s1;
	logic [fmcd_pkg::IDX_W-1:0]          idx_s1;
	logic [fmcd_pkg::ENTRIES-1:0]        valid_q;
	logic                                hit_q, free_q;
	logic [fmcd_pkg::IDX_W-1:0]          hit_idx_q, free_idx_q;
	fmcd_pkg::entry_t                    hit_ent_q;

	fmcd_pkg::entry_t                    rdata, rd_ent, wdata;
	logic                                accept, occupied, wr_req, we;
	logic [fmcd_pkg::IDX_W-1:0]          waddr;
	logic [fmcd_pkg::NUM_PROCS-1:0]      rbit, smask, left;
	fmcd_pkg::emit_job_t                 job;
	fmcd_pkg::emit_stat_t                emit_stat;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= fmcd_pkg::OFFSET_RESET;
			active_q <= fmcd_pkg::ACTIVE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				fmcd_pkg::REG_OFFSET_BITS:  offset_q <= cfg.data;
				fmcd_pkg::REG_ACTIVE_PROCS: active_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Sequence one request: scan, drain the last read, update, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q   <= fmcd_pkg::cmd_t'(req.cmd);
						addr_q  <= req.req_addr;
						reqr_q  <= req.requester;
						tag_q   <= req.req_addr >> offset_q;
						cnt_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					cnt_q <= fmcd_pkg::IDX_W'(cnt_q + 1'b1);
					if (cnt_q == fmcd_pkg::IDX_W'(fmcd_pkg::ENTRIES - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN:   state_q <= S_RESOLVE;
				S_RESOLVE: state_q <= S_EMIT;
				S_EMIT: begin
					if (emit_stat.done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Entry store
	fmcd_ram #(
		.WIDTH (fmcd_pkg::ENTRY_W),
		.DEPTH (fmcd_pkg::ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (state_q == S_SCAN),
		.raddr (cnt_q),
		.rdata (rdata)
	);

	// Track the read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			idx_s1    <= '0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
			idx_s1    <= cnt_q;
		end
	end

	// Mark entries written since reset; others read as free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	assign rd_ent   = valid_q[idx_s1] ? rdata : '0;
	assign occupied = (rd_ent.st != fmcd_pkg::DS_UNCACHED);

	// Record the first hit and the first free entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (accept) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (rd_vld_s1) begin
			if (occupied) begin
				if (!hit_q && rd_ent.tag == tag_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= idx_s1;
					hit_ent_q <= rd_ent;
				end
			end else if (!free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
		end
	end

	assign rbit  = fmcd_pkg::proc_bit(reqr_q);
	assign smask = fmcd_pkg::scan_mask(active_q);
	assign left  = hit_ent_q.sharers & ~rbit;

	// Decide the entry update and the message sequence
	always_comb begin
		job.pre_xfer  = 1'b0;
		job.post_xfer = 1'b0;
		job.scan_kind = fmcd_pkg::MSG_INVALIDATE;
		job.mask      = '0;
		job.req       = reqr_q;
		job.addr      = addr_q;
		job.grant     = fmcd_pkg::DS_UNCACHED;
		job.status    = fmcd_pkg::ST_OK;
		wr_req        = 1'b0;
		waddr         = hit_idx_q;
		wdata         = hit_ent_q;
		if (cmd_q inside {fmcd_pkg::CMD_READ, fmcd_pkg::CMD_READ_EXCL} && !hit_q) begin
			if (!free_q) begin
				job.status = fmcd_pkg::ST_FULL;
			end else begin
				wr_req = 1'b1;
				waddr  = free_idx_q;
				wdata  = '{tag: tag_q, st: fmcd_pkg::DS_EXCL, sharers: rbit};
				if (cmd_q == fmcd_pkg::CMD_READ) begin
					job.grant = fmcd_pkg::DS_EXCL;
				end
			end
		end else if (!hit_q) begin
			job.status = fmcd_pkg::ST_MISSING;
		end else begin
			wr_req = 1'b1;
			case (cmd_q)
				fmcd_pkg::CMD_READ: begin
					if (hit_ent_q.st == fmcd_pkg::DS_EXCL) begin
						job.scan_kind = fmcd_pkg::MSG_INTERVENE;
						job.mask      = hit_ent_q.sharers & smask;
						job.post_xfer = 1'b1;
					end
					job.grant = fmcd_pkg::DS_SHARED;
					wdata = '{tag: tag_q, st: fmcd_pkg::DS_SHARED,
						sharers: hit_ent_q.sharers | rbit};
				end
				fmcd_pkg::CMD_READ_EXCL, fmcd_pkg::CMD_UPGRADE: begin
					job.pre_xfer = (cmd_q == fmcd_pkg::CMD_READ_EXCL) &&
						(hit_ent_q.st == fmcd_pkg::DS_EXCL);
					job.mask = left & smask;
					wdata = '{tag: tag_q, st: fmcd_pkg::DS_EXCL, sharers: rbit};
				end
				fmcd_pkg::CMD_UNCACHE: begin
					if ((left & smask) == '0) begin
						wdata = '0;
					end else begin
						wdata = '{tag: tag_q, st: hit_ent_q.st, sharers: left};
					end
				end
				default: wr_req = 1'b0;
			endcase
		end
	end

	assign we = (state_q == S_RESOLVE) && wr_req;

	// Message emitter and response register
	fmcd_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_RESOLVE),
		.job    (job),
		.stat   (emit_stat),
		.rsp    (rsp)
	);

`ifndef SYNTH
	a_emit_idle_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !emit_stat.busy)
		else $error("emitter busy during tag search");

	a_last_is_complete: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.last == (rsp.msg_kind == fmcd_pkg::MSG_COMPLETE)))
		else $error("last flag does not match completion item");

	a_error_on_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != fmcd_pkg::ST_OK) |->
		(rsp.last && rsp.granted_state == fmcd_pkg::DS_UNCACHED))
		else $error("error status on a non-completion item or with a grant");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> !we)
		else $error("entry written twice for one request");
`endif

endmodule

// ----- tb/sv/tb_full_map_coherence_directory_core.sv -----
// Self-checking testbench of the full-map coherence directory core.
module tb_full_map_coherence_directory_core;
	import fmcd_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int TIMEOUT_CYCLES = 1_000_000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int TAIL_CYCLES    = ENTRIES + NUM_PROCS + 16;
	localparam int TAIL_LIMIT     = 200_000;
	localparam int LONG_STALL     = 2500;
	localparam int HOT_TAGS       = 6;

	// One message the directory is due to send
	typedef struct {
		msg_t              kind;
		logic [REQ_W-1:0]  target;
		logic [ADDR_W-1:0] addr;
		dstate_t           grant;
		status_t           status;
		logic              last;
	} dir_msg_t;

	logic clk;
	logic arst_n;

	fmcd_req_if req_ch();
	fmcd_rsp_if rsp_ch();
	fmcd_cfg_if cfg_ch();

	full_map_coherence_directory_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Directory image and register copies
	logic [TAG_W-1:0]      tag_mem    [ENTRIES];
	dstate_t               state_mem  [ENTRIES];
	logic [NUM_PROCS-1:0]  sharer_mem [ENTRIES];
	logic [CFG_DATA_W-1:0] shift_amt;
	logic [CFG_DATA_W-1:0] active_cnt;

	dir_msg_t          msgs_due[$];
	logic [TAG_W-1:0]  hot_tags[HOT_TAGS];
	int                fail_count;
	logic              idling_on;
	int                stall_trigger;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("tb_full_map_coherence_directory_core failed");
		$finish;
	end

	function automatic void push_msg(msg_t kind, logic [REQ_W-1:0] target,
		logic [ADDR_W-1:0] addr, dstate_t grant, status_t status, logic last);
		dir_msg_t m;
		m.kind   = kind;
		m.target = target;
		m.addr   = addr;
		m.grant  = grant;
		m.status = status;
		m.last   = last;
		msgs_due.push_back(m);
	endfunction

	// Update the directory image for one request and queue the messages it causes
	function automatic void apply_request(cmd_t c, logic [ADDR_W-1:0] a, logic [REQ_W-1:0] r);
		logic [TAG_W-1:0]     tag;
		logic [NUM_PROCS-1:0] rbit;
		logic [NUM_PROCS-1:0] scan;
		int                   hit;
		int                   free_idx;
		tag  = a >> shift_amt;
		rbit = '0;
		if (int'(r) < NUM_PROCS)
			rbit[r] = 1'b1;
		for (int i = 0; i < NUM_PROCS; i++)
			scan[i] = (i < int'(active_cnt));
		hit      = -1;
		free_idx = -1;
		for (int e = 0; e < ENTRIES; e++) begin
			if (state_mem[e] != DS_UNCACHED) begin
				if (hit < 0 && tag_mem[e] == tag)
					hit = e;
			end else if (free_idx < 0) begin
				free_idx = e;
			end
		end

		// Allocate on a read miss, or report a full table
		if ((c == CMD_READ || c == CMD_READ_EXCL) && hit < 0) begin
			if (free_idx < 0) begin
				push_msg(MSG_COMPLETE, r, a, DS_UNCACHED, ST_FULL, 1'b1);
				return;
			end
			tag_mem[free_idx]    = tag;
			state_mem[free_idx]  = DS_EXCL;
			sharer_mem[free_idx] = rbit;
			push_msg(MSG_COMPLETE, r, a, (c == CMD_READ) ? DS_EXCL : DS_UNCACHED, ST_OK, 1'b1);
			return;
		end
		if (hit < 0) begin
			push_msg(MSG_COMPLETE, r, a, DS_UNCACHED, ST_MISSING, 1'b1);
			return;
		end

		case (c)
			CMD_READ: begin
				if (state_mem[hit] == DS_EXCL) begin
					for (int i = 0; i < NUM_PROCS; i++)
						if (scan[i] && sharer_mem[hit][i])
							push_msg(MSG_INTERVENE, REQ_W'(i), a, DS_UNCACHED, ST_OK, 1'b0);
					sharer_mem[hit] |= rbit;
					state_mem[hit]   = DS_SHARED;
					push_msg(MSG_TRANSFER, r, a, DS_UNCACHED, ST_OK, 1'b0);
				end else begin
					sharer_mem[hit] |= rbit;
				end
				push_msg(MSG_COMPLETE, r, a, DS_SHARED, ST_OK, 1'b1);
			end
			CMD_READ_EXCL, CMD_UPGRADE: begin
				if (c == CMD_READ_EXCL && state_mem[hit] == DS_EXCL)
					push_msg(MSG_TRANSFER, r, a, DS_UNCACHED, ST_OK, 1'b0);
				for (int i = 0; i < NUM_PROCS; i++)
					if (scan[i] && sharer_mem[hit][i] && i != int'(r))
						push_msg(MSG_INVALIDATE, REQ_W'(i), a, DS_UNCACHED, ST_OK, 1'b0);
				sharer_mem[hit] = rbit;
				state_mem[hit]  = DS_EXCL;
				push_msg(MSG_COMPLETE, r, a, DS_UNCACHED, ST_OK, 1'b1);
			end
			default: begin
				// Drop the requester; free the entry once no scanned sharer is left
				sharer_mem[hit] &= ~rbit;
				if ((sharer_mem[hit] & scan) == '0) begin
					tag_mem[hit]    = '0;
					state_mem[hit]  = DS_UNCACHED;
					sharer_mem[hit] = '0;
				end
				push_msg(MSG_COMPLETE, r, a, DS_UNCACHED, ST_OK, 1'b1);
			end
		endcase
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Match one accepted message against the oldest one due
	task automatic check_msg();
		dir_msg_t m;
		if (msgs_due.size() == 0) begin
			$error("unexpected message: kind %0d proc %0d addr %h", rsp_ch.msg_kind,
				rsp_ch.target_proc, rsp_ch.msg_addr);
			fail_count++;
			return;
		end
		m = msgs_due.pop_front();
		compare_field("msg_kind", 32'(m.kind), 32'(rsp_ch.msg_kind));
		compare_field("target_proc", 32'(m.target), 32'(rsp_ch.target_proc));
		compare_field("msg_addr", m.addr, rsp_ch.msg_addr);
		compare_field("granted_state", 32'(m.grant), 32'(rsp_ch.granted_state));
		compare_field("status", 32'(m.status), 32'(rsp_ch.status));
		compare_field("last", 32'(m.last), 32'(rsp_ch.last));
	endtask

	// Offer one request, after a random gap if idling is on; return at the edge that takes it
	task automatic send_request(cmd_t c, logic [ADDR_W-1:0] a, logic [REQ_W-1:0] r);
		int gap;
		gap = idling_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.cmd       <= c;
		req_ch.req_addr  <= a;
		req_ch.requester <= r;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		apply_request(c, a, r);
	endtask

	// Hold requests until every due message has come and the core has settled
	task automatic drain_directory();
		req_ch.valid <= 1'b0;
		while (msgs_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers back to back while the core is idle
	task automatic set_config(logic [CFG_DATA_W-1:0] shift, logic [CFG_DATA_W-1:0] active);
		drain_directory();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= REG_OFFSET_BITS;
		cfg_ch.data  <= shift;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		shift_amt     = shift;
		cfg_ch.index <= REG_ACTIVE_PROCS;
		cfg_ch.data  <= active;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		active_cnt    = active;
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly reuse a few hot blocks with random offset bits, sometimes any address
	function automatic logic [ADDR_W-1:0] pick_address();
		logic [ADDR_W-1:0] low_mask;
		low_mask = (32'h1 << shift_amt) - 32'h1;
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		return (hot_tags[$urandom_range(0, HOT_TAGS - 1)] << shift_amt) | ($urandom & low_mask);
	endfunction

	function automatic cmd_t pick_cmd();
		int w;
		w = $urandom_range(0, 9);
		if (w < 4)
			return CMD_READ;
		if (w < 6)
			return CMD_READ_EXCL;
		if (w < 8)
			return CMD_UPGRADE;
		return CMD_UNCACHE;
	endfunction

	// Address whose tag is not in the directory
	function automatic logic [ADDR_W-1:0] fresh_address();
		logic [ADDR_W-1:0] a;
		bit                taken;
		do begin
			a     = $urandom;
			taken = 1'b0;
			for (int e = 0; e < ENTRIES; e++)
				if (state_mem[e] != DS_UNCACHED && tag_mem[e] == (a >> shift_amt))
					taken = 1'b1;
		end while (taken);
		return a;
	endfunction

	// Walk the MSI transitions with the reset settings
	task automatic test_basic_transitions();
		idling_on <= 1'b1;
		send_request(CMD_READ,      32'h0000_1040, 3'd0);
		send_request(CMD_READ,      32'h0000_107F, 3'd1);
		send_request(CMD_READ,      32'h0000_1040, 3'd2);
		send_request(CMD_UPGRADE,   32'h0000_1041, 3'd1);
		send_request(CMD_READ_EXCL, 32'h0000_1040, 3'd3);
		send_request(CMD_UNCACHE,   32'h0000_1040, 3'd3);
		send_request(CMD_UPGRADE,   32'h0000_1040, 3'd4);
		send_request(CMD_UNCACHE,   32'h0000_1040, 3'd4);
		send_request(CMD_READ_EXCL, 32'hFFFF_FFFF, 3'd7);
		send_request(CMD_READ,      32'hFFFF_FFC0, 3'd6);
		for (int p = 0; p < 6; p++)
			send_request(CMD_READ, 32'hFFFF_FFFF, REQ_W'(p));
		// Every processor shares the block: seven invalidates
		send_request(CMD_READ_EXCL, 32'hFFFF_FFC0, 3'd3);
		send_request(CMD_UNCACHE,   32'hFFFF_FFFF, 3'd3);
		send_request(CMD_READ,      32'h0000_0000, 3'd0);
	endtask

	// Narrow and widen the sharer scan and the tag shift
	task automatic test_scan_limits();
		set_config(4'd6, 4'd3);
		idling_on <= 1'b1;
		send_request(CMD_READ,      32'h0001_2000, 3'd0);
		send_request(CMD_READ,      32'h0001_2000, 3'd5);
		send_request(CMD_READ_EXCL, 32'h0001_2000, 3'd1);
		send_request(CMD_UNCACHE,   32'h0001_2000, 3'd1);
		// Requester beyond the scan keeps a bit that does not hold the entry
		send_request(CMD_READ,      32'h0003_4000, 3'd4);
		send_request(CMD_UNCACHE,   32'h0003_4000, 3'd2);

		set_config(4'd0, 4'd0);
		send_request(CMD_READ,      32'hA5A5_5A5A, 3'd3);
		send_request(CMD_READ,      32'hA5A5_5A5A, 3'd6);
		send_request(CMD_UNCACHE,   32'hA5A5_5A5A, 3'd6);
		send_request(CMD_UPGRADE,   32'hA5A5_5A5A, 3'd3);

		set_config(4'd15, 4'd15);
		send_request(CMD_READ,      32'h8000_7FFF, 3'd2);
		send_request(CMD_READ,      32'h8000_0000, 3'd7);
		send_request(CMD_READ_EXCL, 32'h8000_4000, 3'd0);
	endtask

	// Random traffic on a few hot blocks under one setting
	task automatic test_random_phase(logic [CFG_DATA_W-1:0] shift, logic [CFG_DATA_W-1:0] active,
		int count, logic idle);
		set_config(shift, active);
		idling_on <= idle;
		for (int k = 0; k < HOT_TAGS; k++)
			hot_tags[k] = $urandom >> shift_amt;
		repeat (count)
			send_request(pick_cmd(), pick_address(), REQ_W'($urandom_range(0, 7)));
	endtask

	// Block the response side long enough to back up the request side
	task automatic test_backpressure();
		drain_directory();
		idling_on     <= 1'b0;
		stall_trigger <= stall_trigger + 1;
		repeat (12)
			send_request(pick_cmd(), pick_address(), REQ_W'($urandom_range(0, 7)));
		drain_directory();
	endtask

	// Fill every free entry, then miss on a full table, upgrade an absent block and read the last one filled
	task automatic test_directory_full();
		int                spare;
		logic [ADDR_W-1:0] a;
		set_config(4'd12, 4'd8);
		idling_on <= 1'b1;
		spare = 0;
		for (int e = 0; e < ENTRIES; e++)
			if (state_mem[e] == DS_UNCACHED)
				spare++;
		repeat (spare) begin
			a = fresh_address();
			send_request($urandom_range(0, 1) ? CMD_READ : CMD_READ_EXCL, a,
				REQ_W'($urandom_range(0, 7)));
		end
		send_request(CMD_READ,      fresh_address(), 3'd5);
		send_request(CMD_READ_EXCL, fresh_address(), 3'd2);
		send_request(CMD_UPGRADE,   fresh_address(), 3'd1);
		send_request(CMD_READ,      a, 3'd6);
	endtask

	// Accept and check messages with random stalls and one long hold-off
	initial begin : rsp_side
		int rsp_wait;
		int stalls_seen;
		rsp_wait    = 0;
		stalls_seen = 0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				check_msg();
				rsp_wait = idling_on ? $urandom_range(0, 6) : 0;
			end
			if (stall_trigger != stalls_seen) begin
				stalls_seen = stall_trigger;
				rsp_wait    = LONG_STALL;
			end
			if (rsp_wait > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_wait--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : main_seq
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.cmd       = CMD_READ;
		req_ch.req_addr  = '0;
		req_ch.requester = '0;
		rsp_ch.ready     = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = REG_OFFSET_BITS;
		cfg_ch.data      = '0;
		idling_on        = 1'b1;
		stall_trigger    = 0;
		fail_count       = 0;
		shift_amt        = OFFSET_RESET;
		active_cnt       = ACTIVE_RESET;
		for (int e = 0; e < ENTRIES; e++) begin
			tag_mem[e]    = '0;
			state_mem[e]  = DS_UNCACHED;
			sharer_mem[e] = '0;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_transitions();
		test_scan_limits();
		test_random_phase(4'd0, 4'd1, 20, 1'b1);
		test_random_phase(4'd15, 4'd8, 20, 1'b0);
		test_random_phase(4'd12, 4'd0, 20, 1'b1);
		test_random_phase(4'd3, 4'd15, 20, 1'b1);
		test_random_phase(CFG_DATA_W'($urandom_range(0, 15)),
			CFG_DATA_W'($urandom_range(1, 8)), 20, 1'b1);
		test_backpressure();
		test_directory_full();

		// Wait out the last messages, then watch for strays
		req_ch.valid <= 1'b0;
		for (int n = 0; n < TAIL_LIMIT && msgs_due.size() != 0; n++)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (msgs_due.size() != 0) begin
			$error("%0d messages never arrived", msgs_due.size());
			fail_count++;
		end

		if (fail_count == 0)
			$display("tb_full_map_coherence_directory_core passed");
		else
			$display("tb_full_map_coherence_directory_core failed");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/fmcd_pkg.sv
hw/rtl/fmcd_if.sv
hw/rtl/fmcd_ram.sv
hw/rtl/fmcd_emit.sv
hw/rtl/full_map_coherence_directory_core.sv
tb/sv/tb_full_map_coherence_directory_core.sv
